@@ rtl/nltn_pkg.sv @@
`default_nettype none
package nltn_pkg;

  localparam logic       OP_FRAME     = 1'b0;
  localparam logic       OP_WRITE     = 1'b1;

  localparam logic [1:0] STAT_VALID   = 2'd0;
  localparam logic [1:0] STAT_NODATA  = 2'd1;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_COUNT    = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;
  localparam logic [1:0] REG_PERIOD   = 2'd3;

  localparam int         EN_CROSS     = 0;
  localparam int         EN_PERIOD    = 1;

  localparam int         RSN_CROSS    = 0;
  localparam int         RSN_PERIOD   = 1;
  localparam int         RSN_INITIAL  = 2;

  typedef struct packed {
    logic [1:0]  notify_enable;
    logic [4:0]  threshold_count;
    logic [15:0] threshold_hold_frames;
    logic [15:0] period_frames;
  } cfg_t;

  typedef struct packed {
    logic [15:0] noise_level_mba;
    logic [15:0] crossed_level_mba;
    logic [2:0]  reason_mask;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UP,
    ST_DOWN,
    ST_NOTIFY
  } st_t;

endpackage
`default_nettype wire

@@ rtl/nltn_tbl_ram.sv @@
`default_nettype none
module nltn_tbl_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  // Each entry holds the threshold in the upper half and the hysteresis below it.
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/nltn_ctrl.sv @@
`default_nettype none
module nltn_ctrl
  import nltn_pkg::*;
#(
  parameter int MAX_THRESHOLDS = 16,
  parameter int DBA_TO_MBA     = 1000,
  parameter int IW             = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_opcode,
  input  wire logic [1:0]    in_frame_status,
  input  wire logic [7:0]    in_min_level_dba,
  input  wire logic [3:0]    in_entry_index,
  input  wire logic [15:0]   in_entry_threshold_mba,
  input  wire logic [15:0]   in_entry_hysteresis_mba,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output logic [31:0]        mem_wdata,
  output logic               mem_re,
  output logic [IW-1:0]      mem_raddr,
  input  wire logic [31:0]   mem_rdata,
  output logic               res_valid,
  input  wire logic          res_ready,
  output res_t               res
);

  localparam int CW  = $clog2(MAX_THRESHOLDS + 1);
  localparam int NW  = (CW > 5) ? CW : 5;
  localparam int WW  = NW + 1;
  localparam int MW  = (DBA_TO_MBA > 1) ? $clog2(DBA_TO_MBA + 1) : 1;
  localparam int PW0 = 8 + MW;
  localparam int XW  = (PW0 > 17) ? PW0 : 17;

  st_t                state_r, state_nxt;
  logic signed [WW-1:0] wi_r, wi_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [CW-1:0]      upper_r, upper_nxt;
  logic signed [IW:0] lower_r, lower_nxt;
  logic               cross_r, cross_nxt;
  logic               init_r, init_nxt;
  logic [15:0]        hold_r, hold_nxt;
  logic [15:0]        period_r, period_nxt;
  logic [15:0]        level_r, level_nxt;
  logic [15:0]        cur_thr_r, cur_thr_nxt;

  logic               accept;
  logic [XW-1:0]      prod;
  logic [15:0]        scaled;
  logic [NW-1:0]      cnt_x;
  logic signed [WW-1:0] n_s;
  logic [15:0]        rd_thr, rd_hys;
  logic [16:0]        up_sum;
  logic [15:0]        up_edge, dn_edge;
  logic signed [WW-1:0] wi_inc, wi_dec, up_start, dn_start;
  logic [15:0]        hold_inc, period_inc;
  logic [2:0]         reason;
  logic [15:0]        crossed;
  logic               hold_clr, period_clr, cross_fire;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign prod   = XW'(in_min_level_dba) * XW'(DBA_TO_MBA);
  assign scaled = (prod > XW'(17'h0FFFF)) ? 16'hFFFF : prod[15:0];

  assign cnt_x = NW'(cfg.threshold_count);
  assign n_s   = (cnt_x > NW'(MAX_THRESHOLDS)) ? $signed({1'b0, NW'(MAX_THRESHOLDS)})
                                                : $signed({1'b0, cnt_x});

  assign rd_thr  = mem_rdata[31:16];
  assign rd_hys  = mem_rdata[15:0];
  assign up_sum  = {1'b0, rd_thr} + {1'b0, rd_hys};
  assign up_edge = up_sum[16] ? 16'hFFFF : up_sum[15:0];
  assign dn_edge = (rd_thr > rd_hys) ? (rd_thr - rd_hys) : 16'd0;

  assign wi_inc   = wi_r + WW'(1);
  assign wi_dec   = wi_r - WW'(1);
  assign up_start = $signed({1'b0, NW'(upper_r)});
  assign dn_start = WW'(lower_r);

  assign hold_inc   = (hold_r != 16'hFFFF) ? hold_r + 16'd1 : hold_r;
  assign period_inc = (period_r != 16'hFFFF) ? period_r + 16'd1 : period_r;

  // Notice decision for the frame that has finished its table walk.
  always_comb begin
    reason     = '0;
    crossed    = '0;
    cross_fire = 1'b0;
    hold_clr   = 1'b0;
    period_clr = 1'b0;
    if (cfg.notify_enable[EN_CROSS]) begin
      if (hold_inc >= cfg.threshold_hold_frames && cross_r) begin
        cross_fire          = 1'b1;
        hold_clr            = 1'b1;
        crossed             = cur_thr_r;
        reason[RSN_CROSS]   = 1'b1;
      end
    end
    if (cfg.notify_enable[EN_PERIOD]) begin
      if (period_inc >= cfg.period_frames) begin
        period_clr          = 1'b1;
        reason[RSN_PERIOD]  = 1'b1;
      end
    end
    if (init_r) begin
      crossed             = cur_thr_r;
      reason[RSN_INITIAL] = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wi_nxt      = wi_r;
    cur_nxt     = cur_r;
    upper_nxt   = upper_r;
    lower_nxt   = lower_r;
    cross_nxt   = cross_r;
    init_nxt    = init_r;
    hold_nxt    = hold_r;
    period_nxt  = period_r;
    level_nxt   = level_r;
    cur_thr_nxt = cur_thr_r;
    mem_we      = 1'b0;
    mem_waddr   = IW'(in_entry_index);
    mem_wdata   = {in_entry_threshold_mba, in_entry_hysteresis_mba};
    mem_re      = 1'b0;
    mem_raddr   = cur_r;
    res_valid   = 1'b0;
    res.noise_level_mba   = level_r;
    res.crossed_level_mba = crossed;
    res.reason_mask       = reason;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_WRITE) begin
            mem_we = (32'(in_entry_index) < MAX_THRESHOLDS);
          end else if (in_frame_status == STAT_NODATA) begin
            init_nxt = 1'b1;
          end else if (in_frame_status == STAT_VALID) begin
            level_nxt = scaled;
            mem_re    = 1'b1;
            mem_raddr = cur_r;
            state_nxt = ST_CMP;
          end
        end
      end

      ST_CMP: begin
        cur_thr_nxt = rd_thr;
        state_nxt   = ST_NOTIFY;
        if (cfg.notify_enable[EN_CROSS]) begin
          if (level_r > rd_thr) begin
            if (up_start < n_s) begin
              wi_nxt    = up_start;
              mem_re    = 1'b1;
              mem_raddr = up_start[IW-1:0];
              state_nxt = ST_UP;
            end
          end else if (level_r < rd_thr) begin
            if (dn_start >= 0) begin
              wi_nxt    = dn_start;
              mem_re    = 1'b1;
              mem_raddr = dn_start[IW-1:0];
              state_nxt = ST_DOWN;
            end
          end
        end
      end

      ST_UP: begin
        state_nxt = ST_NOTIFY;
        if (level_r >= up_edge) begin
          cur_nxt     = wi_r[IW-1:0];
          upper_nxt   = wi_inc[CW-1:0];
          lower_nxt   = wi_r[IW:0];
          cross_nxt   = 1'b1;
          cur_thr_nxt = rd_thr;
          if (wi_inc < n_s) begin
            wi_nxt    = wi_inc;
            mem_re    = 1'b1;
            mem_raddr = wi_inc[IW-1:0];
            state_nxt = ST_UP;
          end
        end
      end

      ST_DOWN: begin
        state_nxt = ST_NOTIFY;
        if (level_r <= dn_edge) begin
          cur_nxt     = wi_r[IW-1:0];
          upper_nxt   = wi_r[CW-1:0];
          lower_nxt   = wi_dec[IW:0];
          cross_nxt   = 1'b1;
          cur_thr_nxt = rd_thr;
          if (wi_dec >= 0) begin
            wi_nxt    = wi_dec;
            mem_re    = 1'b1;
            mem_raddr = wi_dec[IW-1:0];
            state_nxt = ST_DOWN;
          end
        end
      end

      ST_NOTIFY: begin
        res_valid = (reason != 3'd0);
        // Counters and pending flags move only once the notice can leave.
        if (reason == 3'd0 || res_ready) begin
          if (cfg.notify_enable[EN_CROSS]) begin
            hold_nxt = hold_clr ? 16'd0 : hold_inc;
          end
          if (cfg.notify_enable[EN_PERIOD]) begin
            period_nxt = period_clr ? 16'd0 : period_inc;
          end
          if (cross_fire) begin
            cross_nxt = 1'b0;
          end
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cur_r    <= '0;
      upper_r  <= '0;
      lower_r  <= '0;
      cross_r  <= 1'b0;
      init_r   <= 1'b0;
      hold_r   <= '0;
      period_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      upper_r  <= upper_nxt;
      lower_r  <= lower_nxt;
      cross_r  <= cross_nxt;
      init_r   <= init_nxt;
      hold_r   <= hold_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wi_r      <= wi_nxt;
    level_r   <= level_nxt;
    cur_thr_r <= cur_thr_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/noise_level_threshold_notifier.sv @@
// Channel  Direction  Handshake         Payload
// in_      input      in_valid/stall    opcode, status, level, table entry
// out_     output     out_valid/stall   level, crossed threshold, reason mask
// cfg_     input      cfg_we            cfg_index, cfg_data
//
// A table write, a no-data frame or a failed frame does not stall the input.
// A valid frame stalls it while at most MAX_THRESHOLDS table entries are walked
// and its notice, if any, is handed on; the table memory's read port visits one
// entry per cycle. Synchronous active-low reset clears control state; the
// table contents are not cleared. A notice waits in the output register, and
// the next frame may be taken meanwhile; a second notice waits until it leaves.
`default_nettype none
module noise_level_threshold_notifier
  import nltn_pkg::*;
#(
  parameter int MAX_THRESHOLDS = 16,
  parameter int DBA_TO_MBA     = 1000
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [1:0]  in_frame_status,
  input  wire logic [7:0]  in_min_level_dba,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [15:0] in_entry_threshold_mba,
  input  wire logic [15:0] in_entry_hysteresis_mba,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_noise_level_mba,
  output logic [15:0]      out_crossed_level_mba,
  output logic [2:0]       out_reason_mask,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;

  cfg_t          cfg_r;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: cfg_r.notify_enable         <= cfg_data[1:0];
        REG_COUNT:  cfg_r.threshold_count       <= cfg_data[4:0];
        REG_HOLD:   cfg_r.threshold_hold_frames <= cfg_data;
        REG_PERIOD: cfg_r.period_frames         <= cfg_data;
        default:    cfg_r                       <= cfg_r;
      endcase
    end
  end

  nltn_tbl_ram #(
    .DEPTH (MAX_THRESHOLDS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nltn_ctrl #(
    .MAX_THRESHOLDS (MAX_THRESHOLDS),
    .DBA_TO_MBA     (DBA_TO_MBA),
    .IW             (IW)
  ) u_ctrl (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_opcode),
    .in_frame_status         (in_frame_status),
    .in_min_level_dba        (in_min_level_dba),
    .in_entry_index          (in_entry_index),
    .in_entry_threshold_mba  (in_entry_threshold_mba),
    .in_entry_hysteresis_mba (in_entry_hysteresis_mba),
    .mem_we                  (mem_we),
    .mem_waddr               (mem_waddr),
    .mem_wdata               (mem_wdata),
    .mem_re                  (mem_re),
    .mem_raddr               (mem_raddr),
    .mem_rdata               (mem_rdata),
    .res_valid               (res_valid),
    .res_ready               (res_ready),
    .res                     (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_noise_level_mba   = out_r.noise_level_mba;
  assign out_crossed_level_mba = out_r.crossed_level_mba;
  assign out_reason_mask       = out_r.reason_mask;

`ifndef SYNTHESIS
  // A table write completes in the cycle it is taken.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OP_WRITE) |=> !in_stall)
    else $error("table write did not return to idle");

  // A valid frame always goes through the table read.
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OP_FRAME && in_frame_status == STAT_VALID)
    |=> in_stall)
    else $error("valid frame did not start a table read");

  // A notice handed to the output register shows up with a reason.
  a_notice_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (out_valid && out_reason_mask != 3'd0))
    else $error("notice lost on its way to the output");
`endif

endmodule
`default_nettype wire
